FILE: design/wsd_pkg.sv
package wsd_pkg;

  // Width of the numeric argument as it is accumulated; the result port is always 64 bits.
  localparam int ARG_WIDTH = 64;
  localparam int OUT_ARG_WIDTH = 64;

  // Source characters that carry meaning.
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;

  // Token codes.
  localparam logic [1:0] TOK_NONE = 2'd0;
  localparam logic [1:0] TOK_S    = 2'd1;
  localparam logic [1:0] TOK_T    = 2'd2;
  localparam logic [1:0] TOK_L    = 2'd3;

  // Decode positions.
  localparam logic [4:0] P_IDLE   = 5'd0;
  localparam logic [4:0] P_T      = 5'd1;
  localparam logic [4:0] P_STK    = 5'd2;
  localparam logic [4:0] P_STK_T  = 5'd3;
  localparam logic [4:0] P_STK_L  = 5'd4;
  localparam logic [4:0] P_ARI    = 5'd5;
  localparam logic [4:0] P_ARI_S  = 5'd6;
  localparam logic [4:0] P_ARI_T  = 5'd7;
  localparam logic [4:0] P_HEAP   = 5'd8;
  localparam logic [4:0] P_FLOW   = 5'd9;
  localparam logic [4:0] P_FL_S   = 5'd10;
  localparam logic [4:0] P_FL_T   = 5'd11;
  localparam logic [4:0] P_FL_L   = 5'd12;
  localparam logic [4:0] P_IO     = 5'd13;
  localparam logic [4:0] P_IO_S   = 5'd14;
  localparam logic [4:0] P_IO_T   = 5'd15;
  localparam logic [4:0] P_SIGN   = 5'd16;
  localparam logic [4:0] P_DIGITS = 5'd17;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNKNOWN   = 2'd1;
  localparam logic [1:0] ST_SIGN      = 2'd2;
  localparam logic [1:0] ST_PREMATURE = 2'd3;

  // Opcodes.
  localparam logic [4:0] OP_PUSH     = 5'd0;
  localparam logic [4:0] OP_COPY     = 5'd1;
  localparam logic [4:0] OP_SLIDE    = 5'd2;
  localparam logic [4:0] OP_DUP      = 5'd3;
  localparam logic [4:0] OP_SWAP     = 5'd4;
  localparam logic [4:0] OP_DISCARD  = 5'd5;
  localparam logic [4:0] OP_ADD      = 5'd6;
  localparam logic [4:0] OP_SUB      = 5'd7;
  localparam logic [4:0] OP_MUL      = 5'd8;
  localparam logic [4:0] OP_DIV      = 5'd9;
  localparam logic [4:0] OP_MOD      = 5'd10;
  localparam logic [4:0] OP_STORE    = 5'd11;
  localparam logic [4:0] OP_RETRIEVE = 5'd12;
  localparam logic [4:0] OP_MARK     = 5'd13;
  localparam logic [4:0] OP_CALL     = 5'd14;
  localparam logic [4:0] OP_JUMP     = 5'd15;
  localparam logic [4:0] OP_JZ       = 5'd16;
  localparam logic [4:0] OP_JN       = 5'd17;
  localparam logic [4:0] OP_RET      = 5'd18;
  localparam logic [4:0] OP_END      = 5'd19;
  localparam logic [4:0] OP_OUTC     = 5'd20;
  localparam logic [4:0] OP_OUTN     = 5'd21;
  localparam logic [4:0] OP_INC      = 5'd22;
  localparam logic [4:0] OP_INN      = 5'd23;

  // What one token does in the command tree.
  localparam logic [1:0] ACT_GO   = 2'd0;  // move to another position
  localparam logic [1:0] ACT_NUM  = 2'd1;  // opcode that needs a number
  localparam logic [1:0] ACT_DONE = 2'd2;  // finished opcode
  localparam logic [1:0] ACT_BAD  = 2'd3;  // unknown command

  typedef struct packed {
    logic [1:0] kind;
    logic [4:0] val;
  } act_t;

  localparam act_t ACT_UNKNOWN = '{kind: ACT_BAD, val: 5'd0};

  function automatic act_t mk(input logic [1:0] kind, input logic [4:0] val);
    act_t a;
    a.kind = kind;
    a.val  = val;
    return a;
  endfunction

  function automatic act_t pick(input logic [1:0] tok, input act_t a_s, input act_t a_t,
                                input act_t a_l);
    act_t a;
    case (tok)
      TOK_S:   a = a_s;
      TOK_T:   a = a_t;
      default: a = a_l;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] tokenize(input logic [7:0] ch);
    logic [1:0] t;
    case (ch)
      CH_SPACE: t = TOK_S;
      CH_TAB:   t = TOK_T;
      CH_LF:    t = TOK_L;
      default:  t = TOK_NONE;
    endcase
    return t;
  endfunction

  // Command tree walk for every position other than sign and digits.
  // Positions without meaning behave as idle.
  function automatic act_t tree_step(input logic [4:0] pos, input logic [1:0] tok);
    act_t a;
    case (pos)
      P_T:     a = pick(tok, mk(ACT_GO, P_ARI), mk(ACT_GO, P_HEAP), mk(ACT_GO, P_IO));
      P_STK:   a = pick(tok, mk(ACT_NUM, OP_PUSH), mk(ACT_GO, P_STK_T), mk(ACT_GO, P_STK_L));
      P_STK_T: a = pick(tok, mk(ACT_NUM, OP_COPY), ACT_UNKNOWN, mk(ACT_NUM, OP_SLIDE));
      P_STK_L: a = pick(tok, mk(ACT_DONE, OP_DUP), mk(ACT_DONE, OP_SWAP),
                        mk(ACT_DONE, OP_DISCARD));
      P_ARI:   a = pick(tok, mk(ACT_GO, P_ARI_S), mk(ACT_GO, P_ARI_T), ACT_UNKNOWN);
      P_ARI_S: a = pick(tok, mk(ACT_DONE, OP_ADD), mk(ACT_DONE, OP_SUB),
                        mk(ACT_DONE, OP_MUL));
      P_ARI_T: a = pick(tok, mk(ACT_DONE, OP_DIV), mk(ACT_DONE, OP_MOD), ACT_UNKNOWN);
      P_HEAP:  a = pick(tok, mk(ACT_DONE, OP_STORE), mk(ACT_DONE, OP_RETRIEVE), ACT_UNKNOWN);
      P_FLOW:  a = pick(tok, mk(ACT_GO, P_FL_S), mk(ACT_GO, P_FL_T), mk(ACT_GO, P_FL_L));
      P_FL_S:  a = pick(tok, mk(ACT_NUM, OP_MARK), mk(ACT_NUM, OP_CALL),
                        mk(ACT_NUM, OP_JUMP));
      P_FL_T:  a = pick(tok, mk(ACT_NUM, OP_JZ), mk(ACT_NUM, OP_JN), mk(ACT_DONE, OP_RET));
      P_FL_L:  a = pick(tok, ACT_UNKNOWN, ACT_UNKNOWN, mk(ACT_DONE, OP_END));
      P_IO:    a = pick(tok, mk(ACT_GO, P_IO_S), mk(ACT_GO, P_IO_T), ACT_UNKNOWN);
      P_IO_S:  a = pick(tok, mk(ACT_DONE, OP_OUTC), mk(ACT_DONE, OP_OUTN), ACT_UNKNOWN);
      P_IO_T:  a = pick(tok, mk(ACT_DONE, OP_INC), mk(ACT_DONE, OP_INN), ACT_UNKNOWN);
      default: a = pick(tok, mk(ACT_GO, P_STK), mk(ACT_GO, P_T), mk(ACT_GO, P_FLOW));
    endcase
    return a;
  endfunction

endpackage

FILE: design/whitespace_instruction_decoder.sv
// Whitespace instruction decoder.
// Input channel: one source character per word (in_char_code), plus in_end_marker that
// closes a program. Space, tab and linefeed are tokens; all other characters are comments.
// Output channel: one word per decoded instruction or error (out_status, out_opcode,
// out_argument). Most input words produce no output word; they only advance the decoder.
// Both channels use valid/stall: a word moves on a rising edge with valid high and stall low.
// Timing: an input word is captured in an input register and decoded from there; if it
// finishes an instruction or raises an error, its result is loaded into the output
// register, which drives out_valid.
// Throughput: one input word per cycle while no result waits stalled in the output register,
// limited only by the single decode pass between the input register and the output register.
// Reset (synchronous, rst_n low) empties both registers and returns the decoder to idle with
// no pending error.
// When the receiver stalls with a result waiting, the decode stage holds its word and the
// input channel stalls once the input register is full; nothing is dropped.
module whitespace_instruction_decoder
  import wsd_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_char_code,
  input  logic                            in_end_marker,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [4:0]                      out_opcode,
  output logic signed [OUT_ARG_WIDTH-1:0] out_argument
);

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_char_r;
  logic       s1_end_r;

  // Decoder state.
  logic [4:0]           pos_r, pos_nxt;
  logic [4:0]           pend_op_r, pend_op_nxt;
  logic                 neg_r, neg_nxt;
  logic [ARG_WIDTH-1:0] mag_r, mag_nxt;
  logic                 err_r, err_nxt;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [1:0]                      out_status_r, status_nxt;
  logic [4:0]                      out_opcode_r, opcode_nxt;
  logic signed [OUT_ARG_WIDTH-1:0] out_argument_r, argument_nxt;

  logic                        advance;
  logic                        emit;
  logic [1:0]                  tok;
  act_t                        act;
  logic                        mid;
  logic signed [ARG_WIDTH-1:0] arg_val;

  // The decode stage moves whenever the output register is free or being drained.
  assign advance      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = s1_valid_r && !advance;
  assign s1_valid_nxt = in_stall ? s1_valid_r : in_valid;

  assign tok     = tokenize(s1_char_r);
  assign act     = tree_step(pos_r, tok);
  assign mid     = !err_r && (pos_r != P_IDLE) && (pos_r <= P_DIGITS);
  // Two's complement negation keeps the value modulo 2^ARG_WIDTH; the size cast to the
  // output width then sign-extends it.
  assign arg_val = $signed(neg_r ? (~mag_r + {{(ARG_WIDTH-1){1'b0}}, 1'b1}) : mag_r);

  always_comb begin
    pos_nxt      = pos_r;
    pend_op_nxt  = pend_op_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    err_nxt      = err_r;
    emit         = 1'b0;
    status_nxt   = ST_OK;
    opcode_nxt   = OP_PUSH;
    argument_nxt = '0;

    if (advance) begin
      if (s1_end_r) begin
        // End of program: always back to idle, and a half-read instruction is reported.
        pos_nxt = P_IDLE;
        neg_nxt = 1'b0;
        mag_nxt = '0;
        err_nxt = 1'b0;
        if (mid) begin
          emit       = 1'b1;
          status_nxt = ST_PREMATURE;
        end
      end else if (!err_r && tok != TOK_NONE) begin
        case (pos_r)
          P_SIGN: begin
            if (tok == TOK_L) begin
              emit       = 1'b1;
              status_nxt = ST_SIGN;
              pos_nxt    = P_IDLE;
              neg_nxt    = 1'b0;
              mag_nxt    = '0;
              err_nxt    = 1'b1;
            end else begin
              neg_nxt = (tok == TOK_T);
              mag_nxt = '0;
              pos_nxt = P_DIGITS;
            end
          end
          P_DIGITS: begin
            if (tok == TOK_L) begin
              emit         = 1'b1;
              opcode_nxt   = pend_op_r;
              argument_nxt = OUT_ARG_WIDTH'(arg_val);
              pos_nxt      = P_IDLE;
              neg_nxt      = 1'b0;
              mag_nxt      = '0;
            end else begin
              // Binary digits arrive most significant first; space is 0, tab is 1.
              mag_nxt = {mag_r[ARG_WIDTH-2:0], (tok == TOK_T)};
            end
          end
          default: begin
            case (act.kind)
              ACT_GO: begin
                pos_nxt = act.val;
              end
              ACT_NUM: begin
                pend_op_nxt = act.val;
                neg_nxt     = 1'b0;
                mag_nxt     = '0;
                pos_nxt     = P_SIGN;
              end
              ACT_DONE: begin
                emit       = 1'b1;
                opcode_nxt = act.val;
                pos_nxt    = P_IDLE;
                neg_nxt    = 1'b0;
                mag_nxt    = '0;
              end
              default: begin
                emit       = 1'b1;
                status_nxt = ST_UNKNOWN;
                pos_nxt    = P_IDLE;
                neg_nxt    = 1'b0;
                mag_nxt    = '0;
                err_nxt    = 1'b1;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= P_IDLE;
      pend_op_r   <= OP_PUSH;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      err_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      pend_op_r   <= pend_op_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      err_r       <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char_r <= in_char_code;
      s1_end_r  <= in_end_marker;
    end
    if (emit) begin
      out_status_r   <= status_nxt;
      out_opcode_r   <= opcode_nxt;
      out_argument_r <= argument_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_opcode   = out_opcode_r;
  assign out_argument = out_argument_r;

endmodule
